// ===== rtl/etse_pkg.sv =====
// etse_pkg: shared codes, payload structs and constant tables of the tween slot engine
// no dependencies; every other file but etse_ram refers to it by scoped names
package etse_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int QUEUE_DEPTH   = 2;

    // input op codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_LOOP   = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // ease types
    localparam logic [2:0] EASE_IN      = 3'd1;
    localparam logic [2:0] EASE_OUT     = 3'd2;
    localparam logic [2:0] EASE_INOUT   = 3'd3;
    localparam logic [2:0] EASE_BACK    = 3'd4;
    localparam logic [2:0] EASE_ELASTIC = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_UPDATE  = 3'd0;
    localparam logic [2:0] KIND_STARTED = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_CANCEL  = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;
    localparam logic [2:0] KIND_IDLE    = 3'd5;

    localparam logic [23:0] MIN_DURATION = 24'd1000;
    localparam logic [24:0] ELAPSED_MAX  = 25'h1FFFFFF;
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [17:0] BACK_C1      = 18'd111515;
    localparam logic [17:0] BACK_C2      = 18'd177051;
    localparam logic [17:0] DIV3_RECIP   = 18'd174763;
    localparam int          DIV_STEPS    = 16;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_LOOP,
        CMD_CANCEL,
        CMD_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [15:0]        delta_us;
        logic signed [15:0] start_value;
        logic signed [15:0] end_value;
        logic [23:0]        duration_us;
        logic [2:0]         ease_type;
        logic [31:0]        anim_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         ease;
        logic signed [15:0] start_v;
        logic signed [15:0] end_v;
        logic [23:0]        duration;
        logic [24:0]        elapsed;
        logic signed [15:0] current;
        logic [31:0]        id;
    } slot_entry_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_T_CHECK,
        B_T_LOAD,
        B_T_DIV,
        B_EASE,
        B_LERP0,
        B_LERP1,
        B_S_CHECK,
        B_S_CMP,
        B_S_DONE,
        B_EMIT
    } back_state_t;

    // quarter-wave sine, Q1.16
    function automatic logic [16:0] sine_q(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd6424;
            5'd2:    r = 17'd12785;
            5'd3:    r = 17'd19024;
            5'd4:    r = 17'd25080;
            5'd5:    r = 17'd30893;
            5'd6:    r = 17'd36410;
            5'd7:    r = 17'd41576;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd50660;
            5'd10:   r = 17'd54491;
            5'd11:   r = 17'd57798;
            5'd12:   r = 17'd60547;
            5'd13:   r = 17'd62714;
            5'd14:   r = 17'd64277;
            5'd15:   r = 17'd65220;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // 2^(-k/16), Q1.16
    function automatic logic [16:0] exp2_q(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44377;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40692;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37317;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/etse_ram.sv =====
// etse_ram: generic single write port, single read port ram with registered read
// no dependencies
module etse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/etse_front.sv =====
// etse_front: accepts input transactions, classifies the op and clamps the duration
// depends on etse_pkg
module etse_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [15:0]        s_delta_us,
    input  logic signed [15:0] s_start_value,
    input  logic signed [15:0] s_end_value,
    input  logic [23:0]        s_duration_us,
    input  logic [2:0]         s_ease_type,
    input  logic [31:0]        s_anim_id,
    input  logic               q_ready,
    output logic               q_push,
    output etse_pkg::cmd_t     q_cmd
);
    logic known_op;

    always_comb begin
        known_op = 1'b1;
        q_cmd.op = etse_pkg::CMD_TICK;
        case (s_op)
            etse_pkg::OP_TICK:   q_cmd.op = etse_pkg::CMD_TICK;
            etse_pkg::OP_START:  q_cmd.op = etse_pkg::CMD_START;
            etse_pkg::OP_LOOP:   q_cmd.op = etse_pkg::CMD_LOOP;
            etse_pkg::OP_CANCEL: q_cmd.op = etse_pkg::CMD_CANCEL;
            etse_pkg::OP_QUERY:  q_cmd.op = etse_pkg::CMD_QUERY;
            default:             known_op = 1'b0;
        endcase
        q_cmd.delta_us    = s_delta_us;
        q_cmd.start_value = s_start_value;
        q_cmd.end_value   = s_end_value;
        q_cmd.duration_us = (s_duration_us < etse_pkg::MIN_DURATION) ?
                            etse_pkg::MIN_DURATION : s_duration_us;
        q_cmd.ease_type   = s_ease_type;
        q_cmd.anim_id     = s_anim_id;
    end

    assign s_ready = q_ready;
    // unknown ops are taken and dropped
    assign q_push  = s_valid && q_ready && known_op;
endmodule

// ===== rtl/etse_queue.sv =====
// etse_queue: short command fifo between front and back
// depends on etse_pkg
module etse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  etse_pkg::cmd_t push_cmd,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output etse_pkg::cmd_t pop_cmd
);
    localparam int PW = (etse_pkg::QUEUE_DEPTH > 1) ? $clog2(etse_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(etse_pkg::QUEUE_DEPTH + 1);

    etse_pkg::cmd_t entry_reg [etse_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign not_full  = count_reg != CW'(etse_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(etse_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(etse_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (do_push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end
endmodule

// ===== rtl/etse_back.sv =====
// etse_back: slot table, one shared divider, easing sequencer, lerp and result register
// depends on etse_pkg and etse_ram
module etse_back #(
    parameter int SLOTS = etse_pkg::SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  etse_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [31:0]        m_anim_id_res,
    output logic signed [15:0] m_value,
    output logic               m_finished,
    output logic               m_present,
    output logic               m_last
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EW    = $bits(etse_pkg::slot_entry_t);

    etse_pkg::back_state_t state_reg, state_next;
    etse_pkg::cmd_t        cmd_reg, cmd_next;
    etse_pkg::slot_entry_t entry_reg, entry_next, rd_entry, wr_entry;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   slot_sel, fidx_reg, fidx_next, free_idx, wr_addr;
    logic [SLOTS-1:0]   valid_reg, valid_next, loop_reg, loop_next;
    logic               any_reg, any_next, found_reg, found_next, ret_tick_reg, ret_tick_next;
    logic signed [15:0] fcur_reg, fcur_next;
    logic [31:0]        next_id_reg, next_id_next, scan_key;
    logic [24:0]        el_reg, el_next, rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [16:0]        a_reg, a_next;
    logic [2:0]         es_reg, es_next;
    logic [19:0]        t0_reg, t0_next, t1_reg, t1_next;
    logic [1:0]         q_reg, q_next;
    logic signed [19:0] e_reg, e_next;
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod_reg;

    logic [2:0]         pend_kind_reg, pend_kind_next;
    logic [31:0]        pend_id_reg, pend_id_next;
    logic signed [15:0] pend_value_reg, pend_value_next;
    logic               pend_fin_reg, pend_fin_next, pend_pres_reg, pend_pres_next;
    logic               pend_last_reg, pend_last_next;
    logic               out_load, out_free;

    logic               ram_we, ram_re;
    logic [EW-1:0]      ram_rdata;

    // combinational helpers
    logic               at_end, later_any, free_any;
    logic [25:0]        el_sum, rem_shift;
    logic [24:0]        el_sat;
    logic [16:0]        m_val, u_val;
    logic [19:0]        x_val, y_val;
    logic [17:0]        tm_val;
    logic [16:0]        exp_lo, exp_hi, p_raw, sin_lo, sin_hi, s3_lo, s3_val;
    logic [15:0]        ang;
    logic [14:0]        w_val;
    logic signed [16:0] diff;
    logic signed [21:0] step_v, lerp_v;
    logic signed [15:0] lerp_sat;
    logic               full_a;

    etse_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (slot_sel),
        .rdata (ram_rdata)
    );

    assign rd_entry = etse_pkg::slot_entry_t'(ram_rdata);
    assign slot_sel = idx_reg[IDX_W-1:0];
    assign at_end   = idx_reg == CNT_W'(SLOTS);
    assign out_free = !m_valid || m_ready;
    assign scan_key = (cmd_reg.op == etse_pkg::CMD_START || cmd_reg.op == etse_pkg::CMD_LOOP) ?
                      next_id_reg : cmd_reg.anim_id;

    always_comb begin
        later_any = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (valid_reg[i] && CNT_W'(i) > idx_reg) begin
                later_any = 1'b1;
            end
        end
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // arithmetic helpers
    always_comb begin
        el_sum    = 26'(rd_entry.elapsed) + 26'(cmd_reg.delta_us);
        el_sat    = (el_sum > 26'(etse_pkg::ELAPSED_MAX)) ? etse_pkg::ELAPSED_MAX : el_sum[24:0];
        rem_shift = {rem_reg, 1'b0};
        m_val     = 17'(18'(etse_pkg::ONE_Q16) - 18'(a_reg));
        u_val     = 17'(18'd131072 - {a_reg, 1'b0});
        x_val     = 20'(20'(a_reg) * 20'd10);
        exp_lo    = etse_pkg::exp2_q({1'b0, x_val[15:12]});
        exp_hi    = etse_pkg::exp2_q(5'({1'b0, x_val[15:12]} + 5'd1));
        p_raw     = (exp_lo - 17'(prod_reg >>> 12)) >> x_val[19:16];
        y_val     = x_val + 20'd147456;
        if (y_val >= 20'd786432) begin
            tm_val = 18'(y_val - 20'd786432);
        end else if (y_val >= 20'd589824) begin
            tm_val = 18'(y_val - 20'd589824);
        end else if (y_val >= 20'd393216) begin
            tm_val = 18'(y_val - 20'd393216);
        end else if (y_val >= 20'd196608) begin
            tm_val = 18'(y_val - 20'd196608);
        end else begin
            tm_val = 18'(y_val);
        end
        ang    = 16'(prod_reg >>> 19);
        w_val  = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
        sin_lo = etse_pkg::sine_q({1'b0, w_val[13:10]});
        sin_hi = etse_pkg::sine_q(5'({1'b0, w_val[13:10]} + 5'd1));
        s3_lo  = etse_pkg::sine_q({1'b0, t1_reg[13:10]});
        s3_val = t1_reg[14] ? etse_pkg::ONE_Q16 : 17'(s3_lo + 17'(prod_reg >>> 10));
        diff   = 17'(entry_reg.end_v) - 17'(entry_reg.start_v);
        step_v = 22'(prod_reg >>> 16);
        lerp_v = 22'(entry_reg.start_v) + step_v;
        if (lerp_v > 22'sd32767) begin
            lerp_sat = 16'sh7FFF;
        end else if (lerp_v < -22'sd32768) begin
            lerp_sat = -16'sh8000;
        end else begin
            lerp_sat = 16'(lerp_v);
        end
        full_a = a_reg[16];
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        entry_next      = entry_reg;
        idx_next        = idx_reg;
        fidx_next       = fidx_reg;
        valid_next      = valid_reg;
        loop_next       = loop_reg;
        any_next        = any_reg;
        found_next      = found_reg;
        fcur_next       = fcur_reg;
        ret_tick_next   = ret_tick_reg;
        next_id_next    = next_id_reg;
        el_next         = el_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        es_next         = es_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        q_next          = q_reg;
        e_next          = e_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_value_next = pend_value_reg;
        pend_fin_next   = pend_fin_reg;
        pend_pres_next  = pend_pres_reg;
        pend_last_next  = pend_last_reg;
        mul_a           = '0;
        mul_b           = '0;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        wr_addr         = slot_sel;
        wr_entry        = entry_reg;
        out_load        = 1'b0;

        case (state_reg)
            etse_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    idx_next   = '0;
                    any_next   = 1'b0;
                    found_next = 1'b0;
                    state_next = (q_cmd.op == etse_pkg::CMD_TICK) ?
                                 etse_pkg::B_T_CHECK : etse_pkg::B_S_CHECK;
                end
            end

            etse_pkg::B_T_CHECK: begin
                if (at_end) begin
                    if (any_reg) begin
                        state_next = etse_pkg::B_IDLE;
                    end else begin
                        pend_kind_next  = etse_pkg::KIND_IDLE;
                        pend_id_next    = '0;
                        pend_value_next = '0;
                        pend_fin_next   = 1'b0;
                        pend_pres_next  = 1'b0;
                        pend_last_next  = 1'b1;
                        ret_tick_next   = 1'b0;
                        state_next      = etse_pkg::B_EMIT;
                    end
                end else if (valid_reg[slot_sel]) begin
                    ram_re     = 1'b1;
                    state_next = etse_pkg::B_T_LOAD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            etse_pkg::B_T_LOAD: begin
                entry_next = rd_entry;
                el_next    = el_sat;
                rem_next   = el_sat;
                quo_next   = '0;
                cnt_next   = '0;
                es_next    = '0;
                if (el_sat >= 25'(rd_entry.duration)) begin
                    a_next     = etse_pkg::ONE_Q16;
                    state_next = etse_pkg::B_EASE;
                end else begin
                    state_next = etse_pkg::B_T_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            etse_pkg::B_T_DIV: begin
                if (rem_shift >= 26'(entry_reg.duration)) begin
                    rem_next = 25'(rem_shift - 26'(entry_reg.duration));
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = rem_shift[24:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(etse_pkg::DIV_STEPS - 1)) begin
                    a_next     = {1'b0, quo_next};
                    state_next = etse_pkg::B_EASE;
                end
            end

            etse_pkg::B_EASE: begin
                es_next = es_reg + 1'b1;
                case (entry_reg.ease)
                    etse_pkg::EASE_IN: begin
                        mul_a = 26'(a_reg);
                        mul_b = 26'(a_reg);
                        if (es_reg == 3'd1) begin
                            e_next     = 20'(prod_reg >>> 16);
                            state_next = etse_pkg::B_LERP0;
                        end
                    end
                    etse_pkg::EASE_OUT: begin
                        mul_a = 26'(m_val);
                        mul_b = 26'(m_val);
                        if (es_reg == 3'd1) begin
                            e_next     = 20'(etse_pkg::ONE_Q16) - 20'(prod_reg >>> 16);
                            state_next = etse_pkg::B_LERP0;
                        end
                    end
                    etse_pkg::EASE_INOUT: begin
                        mul_a = a_reg[16:15] == 2'b00 ? 26'(a_reg) : 26'(u_val);
                        mul_b = mul_a;
                        if (es_reg == 3'd1) begin
                            e_next = (a_reg[16:15] == 2'b00) ? 20'(prod_reg >>> 15) :
                                     20'(etse_pkg::ONE_Q16) - 20'(prod_reg >>> 17);
                            state_next = etse_pkg::B_LERP0;
                        end
                    end
                    etse_pkg::EASE_BACK: begin
                        case (es_reg)
                            3'd0: begin
                                mul_a = 26'(m_val);
                                mul_b = 26'(m_val);
                            end
                            3'd1: begin
                                t0_next = 20'(prod_reg >>> 16);
                                mul_a   = 26'(prod_reg >>> 16);
                                mul_b   = 26'(m_val);
                            end
                            3'd2: begin
                                t1_next = 20'(prod_reg >>> 16);
                                mul_a   = 26'(etse_pkg::BACK_C1);
                                mul_b   = 26'(t0_reg);
                            end
                            3'd3: begin
                                t0_next = 20'(prod_reg >>> 16);
                                mul_a   = 26'(etse_pkg::BACK_C2);
                                mul_b   = 26'(t1_reg);
                            end
                            default: begin
                                e_next = 20'(etse_pkg::ONE_Q16) + $signed(t0_reg) -
                                         20'(prod_reg >>> 16);
                                state_next = etse_pkg::B_LERP0;
                            end
                        endcase
                    end
                    etse_pkg::EASE_ELASTIC: begin
                        case (es_reg)
                            3'd0: begin
                                mul_a = 26'(exp_lo - exp_hi);
                                mul_b = 26'(x_val[11:0]);
                                if (a_reg == '0 || full_a) begin
                                    e_next     = 20'(a_reg);
                                    state_next = etse_pkg::B_LERP0;
                                end
                            end
                            3'd1: begin
                                t0_next = 20'(p_raw);
                                mul_a   = 26'(tm_val);
                                mul_b   = 26'(etse_pkg::DIV3_RECIP);
                            end
                            3'd2: begin
                                q_next  = ang[15:14];
                                t1_next = 20'(w_val);
                                mul_a   = 26'(sin_hi - sin_lo);
                                mul_b   = 26'(w_val[9:0]);
                            end
                            3'd3: begin
                                mul_a = 26'(t0_reg);
                                mul_b = 26'(s3_val);
                            end
                            default: begin
                                e_next = q_reg[1] ?
                                         20'(etse_pkg::ONE_Q16) - 20'(prod_reg >>> 16) :
                                         20'(etse_pkg::ONE_Q16) + 20'(prod_reg >>> 16);
                                state_next = etse_pkg::B_LERP0;
                            end
                        endcase
                    end
                    default: begin
                        e_next     = 20'(a_reg);
                        state_next = etse_pkg::B_LERP0;
                    end
                endcase
            end

            etse_pkg::B_LERP0: begin
                mul_a      = 26'(diff);
                mul_b      = 26'(e_reg);
                state_next = etse_pkg::B_LERP1;
            end

            etse_pkg::B_LERP1: begin
                wr_entry         = entry_reg;
                wr_entry.current = lerp_sat;
                wr_entry.elapsed = (full_a && loop_reg[slot_sel]) ? '0 : el_reg;
                ram_we           = 1'b1;
                if (full_a && !loop_reg[slot_sel]) begin
                    valid_next[slot_sel] = 1'b0;
                end
                pend_kind_next  = etse_pkg::KIND_UPDATE;
                pend_id_next    = entry_reg.id;
                pend_value_next = lerp_sat;
                pend_fin_next   = full_a && !loop_reg[slot_sel];
                pend_pres_next  = 1'b0;
                pend_last_next  = !later_any;
                ret_tick_next   = 1'b1;
                any_next        = 1'b1;
                idx_next        = idx_reg + 1'b1;
                state_next      = etse_pkg::B_EMIT;
            end

            // id lookup, one slot read at a time
            etse_pkg::B_S_CHECK: begin
                if (at_end) begin
                    state_next = etse_pkg::B_S_DONE;
                end else if (valid_reg[slot_sel]) begin
                    ram_re     = 1'b1;
                    state_next = etse_pkg::B_S_CMP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            etse_pkg::B_S_CMP: begin
                if (rd_entry.id == scan_key) begin
                    found_next = 1'b1;
                    fidx_next  = slot_sel;
                    fcur_next  = rd_entry.current;
                    state_next = etse_pkg::B_S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = etse_pkg::B_S_CHECK;
                end
            end

            etse_pkg::B_S_DONE: begin
                pend_id_next    = cmd_reg.anim_id;
                pend_value_next = '0;
                pend_fin_next   = 1'b0;
                pend_pres_next  = found_reg;
                pend_last_next  = 1'b1;
                ret_tick_next   = 1'b0;
                state_next      = etse_pkg::B_EMIT;
                case (cmd_reg.op)
                    etse_pkg::CMD_START, etse_pkg::CMD_LOOP: begin
                        pend_pres_next = 1'b0;
                        if (!found_reg && !free_any) begin
                            pend_kind_next = etse_pkg::KIND_FULL;
                            pend_id_next   = '0;
                        end else begin
                            wr_addr           = found_reg ? fidx_reg : free_idx;
                            wr_entry.ease     = cmd_reg.ease_type;
                            wr_entry.start_v  = cmd_reg.start_value;
                            wr_entry.end_v    = cmd_reg.end_value;
                            wr_entry.duration = cmd_reg.duration_us;
                            wr_entry.elapsed  = '0;
                            wr_entry.current  = cmd_reg.start_value;
                            wr_entry.id       = next_id_reg;
                            ram_we            = 1'b1;
                            valid_next[wr_addr] = 1'b1;
                            loop_next[wr_addr]  = cmd_reg.op == etse_pkg::CMD_LOOP;
                            pend_kind_next    = etse_pkg::KIND_STARTED;
                            pend_id_next      = next_id_reg;
                            pend_value_next   = (cmd_reg.op == etse_pkg::CMD_START) ?
                                                cmd_reg.start_value : '0;
                            next_id_next      = next_id_reg + 1'b1;
                        end
                    end
                    etse_pkg::CMD_CANCEL: begin
                        pend_kind_next = etse_pkg::KIND_CANCEL;
                        if (found_reg) begin
                            valid_next[fidx_reg] = 1'b0;
                        end
                    end
                    default: begin
                        pend_kind_next  = etse_pkg::KIND_QUERY;
                        pend_value_next = found_reg ? fcur_reg : '0;
                    end
                endcase
            end

            etse_pkg::B_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ret_tick_reg ? etse_pkg::B_T_CHECK : etse_pkg::B_IDLE;
                end
            end

            default: state_next = etse_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= etse_pkg::B_IDLE;
            valid_reg    <= '0;
            loop_reg     <= '0;
            next_id_reg  <= '0;
            idx_reg      <= '0;
            any_reg      <= 1'b0;
            found_reg    <= 1'b0;
            ret_tick_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            loop_reg     <= loop_next;
            next_id_reg  <= next_id_next;
            idx_reg      <= idx_next;
            any_reg      <= any_next;
            found_reg    <= found_next;
            ret_tick_reg <= ret_tick_next;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
        cmd_reg        <= cmd_next;
        entry_reg      <= entry_next;
        fidx_reg       <= fidx_next;
        fcur_reg       <= fcur_next;
        el_reg         <= el_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        a_reg          <= a_next;
        es_reg         <= es_next;
        t0_reg         <= t0_next;
        t1_reg         <= t1_next;
        q_reg          <= q_next;
        e_reg          <= e_next;
        prod_reg       <= mul_a * mul_b;
        pend_kind_reg  <= pend_kind_next;
        pend_id_reg    <= pend_id_next;
        pend_value_reg <= pend_value_next;
        pend_fin_reg   <= pend_fin_next;
        pend_pres_reg  <= pend_pres_next;
        pend_last_reg  <= pend_last_next;
        if (out_load) begin
            m_kind        <= pend_kind_reg;
            m_anim_id_res <= pend_id_reg;
            m_value       <= pend_value_reg;
            m_finished    <= pend_fin_reg;
            m_present     <= pend_pres_reg;
            m_last        <= pend_last_reg;
        end
    end
endmodule

// ===== rtl/easing_tween_slot_engine_unit.sv =====
// easing_tween_slot_engine_unit: top level of the tween slot engine
// depends on etse_pkg, etse_front, etse_queue, etse_back (and etse_ram below it)
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | op, delta, start/end value, duration, ease, id
//   m_      | out       | m_valid / m_ready  | kind, id, value, finished, present, last
//
// tick: visits each slot in turn; an active slot goes through check, ram read, bit-serial
//   divider unless complete, easing steps, lerp and emit; idle result if no slot is active
// start, cancel, query: scan the slots in turn, reading and comparing the id of each busy
//   slot until one matches, then update the table where needed and emit one result
// reset clears slot valid bits, loop bits and the id counter at once; no clearing pass
// a stalled result register holds the back end; the two-entry queue keeps the front taking until it fills
module easing_tween_slot_engine_unit #(
    parameter int SLOTS = etse_pkg::SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [15:0]        s_delta_us,
    input  logic signed [15:0] s_start_value,
    input  logic signed [15:0] s_end_value,
    input  logic [23:0]        s_duration_us,
    input  logic [2:0]         s_ease_type,
    input  logic [31:0]        s_anim_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [31:0]        m_anim_id_res,
    output logic signed [15:0] m_value,
    output logic               m_finished,
    output logic               m_present,
    output logic               m_last
);
    etse_pkg::cmd_t push_cmd, pop_cmd;
    logic           q_ready, q_push, q_valid, q_pop;

    etse_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_delta_us    (s_delta_us),
        .s_start_value (s_start_value),
        .s_end_value   (s_end_value),
        .s_duration_us (s_duration_us),
        .s_ease_type   (s_ease_type),
        .s_anim_id     (s_anim_id),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    etse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    etse_back #(.SLOTS(SLOTS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_anim_id_res (m_anim_id_res),
        .m_value       (m_value),
        .m_finished    (m_finished),
        .m_present     (m_present),
        .m_last        (m_last)
    );

    // single-result transactions always close their input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != etse_pkg::KIND_UPDATE |-> m_last)
        else $error("non-update result without last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_kind == etse_pkg::KIND_UPDATE)
        else $error("finished flag on a non-update result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_present |-> m_kind == etse_pkg::KIND_CANCEL ||
                                 m_kind == etse_pkg::KIND_QUERY)
        else $error("present flag outside cancel or query");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == etse_pkg::KIND_IDLE || m_kind == etse_pkg::KIND_FULL)
        |-> m_value == '0 && m_anim_id_res == '0)
        else $error("idle or full result carries data");
endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for easing_tween_slot_engine_unit
// depends on etse_pkg and the rtl; predicts every result and compares all its fields at once
module testbench;
    localparam int NSLOT = 8;

    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        delta_us;
        logic signed [15:0] start_value;
        logic signed [15:0] end_value;
        logic [23:0]        duration_us;
        logic [2:0]         ease_type;
        logic [31:0]        anim_id;
    } tween_cmd_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        id;
        logic signed [15:0] value;
        logic               finished;
        logic               present;
        logic               last;
    } tween_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tween_cmd_t s_cmd = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [31:0] m_anim_id_res;
    logic signed [15:0] m_value;
    logic m_finished, m_present, m_last;
    logic in_taken = 1'b0;

    easing_tween_slot_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_cmd.op), .s_delta_us(s_cmd.delta_us),
        .s_start_value(s_cmd.start_value), .s_end_value(s_cmd.end_value),
        .s_duration_us(s_cmd.duration_us), .s_ease_type(s_cmd.ease_type),
        .s_anim_id(s_cmd.anim_id),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_anim_id_res(m_anim_id_res), .m_value(m_value),
        .m_finished(m_finished), .m_present(m_present), .m_last(m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tween table shadow
    logic        tw_valid [NSLOT];
    logic        tw_loop [NSLOT];
    logic [2:0]  tw_ease [NSLOT];
    longint      tw_start [NSLOT];
    longint      tw_end [NSLOT];
    longint      tw_dur [NSLOT];
    longint      tw_elapsed [NSLOT];
    longint      tw_current [NSLOT];
    logic [31:0] tw_id [NSLOT];
    logic [31:0] tw_next_id;

    tween_cmd_t pending_cmds [$];
    tween_res_t expected_res [$];
    int sender_idle = 0, receiver_idle = 0;
    int errors = 0, n_cmds = 0, n_results = 0, n_updates = 0;

    const longint sine_tab [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576,
        46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};
    const longint exp2_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
        48393, 46341, 44377, 42495, 40692, 38968, 37317, 35734, 34219, 32768};

    function automatic longint quarter_wave(longint pos);
        if (pos >= 16384) return 65536;
        return sine_tab[pos >> 10] +
               (((sine_tab[(pos >> 10) + 1] - sine_tab[pos >> 10]) * (pos & 1023)) >> 10);
    endfunction

    function automatic longint elastic_curve(longint a);
        longint x, f, p, ang, q, w, mag;
        if (a == 0) return 0;
        if (a >= 65536) return 65536;
        x = 10 * a;
        f = x & 65535;
        p = exp2_tab[f >> 12] -
            (((exp2_tab[f >> 12] - exp2_tab[(f >> 12) + 1]) * (f & 4095)) >> 12);
        p = p >> (x >> 16);
        ang = ((x + 147456) % 196608) / 3;
        q = (ang >> 14) & 3;
        w = ang & 16383;
        if (q & 1) w = 16384 - w;
        mag = (p * quarter_wave(w)) >> 16;
        return (q >= 2) ? 65536 - mag : 65536 + mag;
    endfunction

    function automatic longint eased_alpha(longint a, logic [2:0] et);
        longint m, m2, m3, u;
        case (et)
            etse_pkg::EASE_IN: return (a * a) >> 16;
            etse_pkg::EASE_OUT: begin
                m = 65536 - a;
                return 65536 - ((m * m) >> 16);
            end
            etse_pkg::EASE_INOUT: begin
                if (a < 32768) return (2 * a * a) >> 16;
                u = 131072 - 2 * a;
                return 65536 - ((u * u) >> 17);
            end
            etse_pkg::EASE_BACK: begin
                m = 65536 - a;
                m2 = (m * m) >> 16;
                m3 = (m2 * m) >> 16;
                return 65536 + ((111515 * m2) >> 16) - ((177051 * m3) >> 16);
            end
            etse_pkg::EASE_ELASTIC: return elastic_curve(a);
            default: return a;
        endcase
    endfunction

    function automatic longint blend_sat(longint s, longint e, longint w);
        longint prod, v;
        prod = (e - s) * w;
        v = s + (prod >>> 16);  // arithmetic shift floors
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int slot_of(logic [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (tw_valid[i] && tw_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void push_res(logic [2:0] kind, logic [31:0] id, longint v,
                                     logic fin, logic pres);
        tween_res_t r;
        r.kind = kind; r.id = id; r.value = v[15:0];
        r.finished = fin; r.present = pres; r.last = 1'b0;
        expected_res.push_back(r);
    endfunction

    function automatic void predict_tween(tween_cmd_t c);
        int s, n;
        longint el, a;
        logic done;
        n = expected_res.size();
        case (c.op)
            etse_pkg::OP_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tw_valid[i]) continue;
                    el = tw_elapsed[i] + c.delta_us;
                    if (el > 33554431) el = 33554431;
                    tw_elapsed[i] = el;
                    a = (el << 16) / tw_dur[i];
                    if (a > 65536) a = 65536;
                    tw_current[i] = blend_sat(tw_start[i], tw_end[i],
                                              eased_alpha(a, tw_ease[i]));
                    done = 1'b0;
                    if (a >= 65536) begin
                        if (tw_loop[i]) tw_elapsed[i] = 0;
                        else done = 1'b1;
                    end
                    push_res(etse_pkg::KIND_UPDATE, tw_id[i], tw_current[i], done, 1'b0);
                    if (done) tw_valid[i] = 1'b0;
                end
                if (expected_res.size() == n)
                    push_res(etse_pkg::KIND_IDLE, 0, 0, 1'b0, 1'b0);
            end
            etse_pkg::OP_START, etse_pkg::OP_LOOP: begin
                s = slot_of(tw_next_id);
                if (s < 0)
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!tw_valid[i]) s = i;
                if (s < 0) begin
                    push_res(etse_pkg::KIND_FULL, 0, 0, 1'b0, 1'b0);
                end else begin
                    tw_valid[s] = 1'b1;
                    tw_loop[s] = (c.op == etse_pkg::OP_LOOP);
                    tw_ease[s] = c.ease_type;
                    tw_start[s] = c.start_value;
                    tw_end[s] = c.end_value;
                    tw_dur[s] = (c.duration_us < 1000) ? 1000 : c.duration_us;
                    tw_elapsed[s] = 0;
                    tw_current[s] = c.start_value;
                    tw_id[s] = tw_next_id;
                    push_res(etse_pkg::KIND_STARTED, tw_next_id,
                             (c.op == etse_pkg::OP_START) ? longint'(c.start_value) : 0,
                             1'b0, 1'b0);
                    tw_next_id++;
                end
            end
            etse_pkg::OP_CANCEL: begin
                s = slot_of(c.anim_id);
                if (s >= 0) tw_valid[s] = 1'b0;
                push_res(etse_pkg::KIND_CANCEL, c.anim_id, 0, 1'b0, s >= 0);
            end
            etse_pkg::OP_QUERY: begin
                s = slot_of(c.anim_id);
                push_res(etse_pkg::KIND_QUERY, c.anim_id, (s >= 0) ? tw_current[s] : 0,
                         1'b0, s >= 0);
            end
            default: ;
        endcase
        if (expected_res.size() > n) expected_res[expected_res.size() - 1].last = 1'b1;
    endfunction

    function automatic tween_cmd_t mk_cmd(logic [2:0] op, logic [15:0] dt,
                                          logic [15:0] sv, logic [15:0] ev,
                                          logic [23:0] dur, logic [2:0] et,
                                          logic [31:0] id);
        tween_cmd_t c;
        c.op = op; c.delta_us = dt; c.start_value = sv; c.end_value = ev;
        c.duration_us = dur; c.ease_type = et; c.anim_id = id;
        return c;
    endfunction

    function automatic tween_cmd_t rand_cmd(logic [31:0] id_hint);
        tween_cmd_t c;
        logic [127:0] rbits;
        int r;
        rbits = {$urandom, $urandom, $urandom, $urandom};
        c = rbits[$bits(tween_cmd_t)-1:0];
        r = $urandom_range(0, 99);
        if (r < 40) c.op = etse_pkg::OP_TICK;
        else if (r < 62) c.op = etse_pkg::OP_START;
        else if (r < 72) c.op = etse_pkg::OP_LOOP;
        else if (r < 82) c.op = etse_pkg::OP_CANCEL;
        else if (r < 94) c.op = etse_pkg::OP_QUERY;
        else c.op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0) c.delta_us = 16'($urandom_range(0, 20000));
        if ($urandom_range(0, 3) != 0) c.duration_us = 24'($urandom_range(0, 100000));
        if ($urandom_range(0, 2) != 0) c.anim_id = id_hint - $urandom_range(1, 10);
        return c;
    endfunction

    // driver: present the next item, hold it until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_taken) begin
                // hold
            end else if (pending_cmds.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle) begin
                s_cmd <= pending_cmds.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge aclk) begin
        tween_res_t got, want;
        if (aresetn) begin
            in_taken = s_valid && s_ready;
            if (s_valid && s_ready) begin
                predict_tween(s_cmd);
                n_cmds++;
            end
            if (m_valid && m_ready) begin
                got = {m_kind, m_anim_id_res, m_value, m_finished, m_present, m_last};
                n_results++;
                if (m_kind == etse_pkg::KIND_UPDATE) n_updates++;
                if (expected_res.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, actual %p", $time, got);
                end else begin
                    want = expected_res.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                    end
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_cmds.size() != 0 || s_valid || expected_res.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tw_valid[i] = 1'b0;
            tw_loop[i] = 1'b0;
        end
        tw_next_id = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle tick, all ease types, extremes, full table, cancel/query
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'd100, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h8000, 16'h7fff, 24'd0,
                                      3'd0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h7fff, 16'h8000,
                                      24'hffffff, etse_pkg::EASE_IN, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_LOOP, 0, 16'h0100, 16'hff00, 24'd3000,
                                      etse_pkg::EASE_OUT, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h8000, 16'h7fff, 24'd5000,
                                      etse_pkg::EASE_INOUT, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h7fff, 16'h8000, 24'd4000,
                                      etse_pkg::EASE_BACK, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h8000, 16'h7fff, 24'd7000,
                                      etse_pkg::EASE_ELASTIC, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_LOOP, 0, 16'h1234, 16'h4321, 24'd999,
                                      3'd6, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h0000, 16'h0a00, 24'd2000,
                                      3'd7, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_START, 0, 16'h0001, 16'h0002, 24'd2000,
                                      0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_QUERY, 0, 0, 0, 0, 0, 32'd3));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'd1200, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'd0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'hffff, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_QUERY, 0, 0, 0, 0, 0, 32'd2));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_QUERY, 0, 0, 0, 0, 0, 32'hffffffff));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 32'd2));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 32'd2));
        pending_cmds.push_back(mk_cmd(3'd5, 16'hffff, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(3'd7, 0, 0, 0, 0, 3'd7, 32'hffffffff));
        pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'hffff, 0, 0, 0, 0, 0));
        // long looping run keeps adding toward elapsed saturation
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(mk_cmd(etse_pkg::OP_TICK, 16'hffff, 0, 0, 0, 0, 0));

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = (ph == 0) ? 8 : (ph == 1) ? 83 : 0;
            receiver_idle = (ph == 0) ? 83 : (ph == 1) ? 8 : 0;
            for (int i = 0; i < 32; i++)
                pending_cmds.push_back(rand_cmd(32'd10 + 32'(n_cmds) / 2));
            drain_all();
        end
        repeat (400) @(posedge aclk);

        $display("covered %0d input transactions, %0d result transactions (%0d updates)",
                 n_cmds, n_results, n_updates);
        if (errors == 0 && expected_res.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== easing_tween_slot_engine_unit.f =====
rtl/etse_pkg.sv
rtl/etse_ram.sv
rtl/etse_front.sv
rtl/etse_queue.sv
rtl/etse_back.sv
rtl/easing_tween_slot_engine_unit.sv
test/testbench.sv
